// ===== rtl/gba_pkg.sv =====
// Shared types and constants of the greedy bandwidth allocator.
// No dependencies; every other file imports this package.
`default_nettype none

package gba_pkg;

   localparam int EDGES   = 64;
   localparam int CLIENTS = 64;

   localparam int OPCODE_W = 2;
   localparam int INDEX_W  = 6;
   localparam int AMOUNT_W = 20;
   localparam int DELAY_W  = 10;

   localparam int EDGE_W    = $clog2(EDGES);
   localparam int DLY_DEPTH = CLIENTS * EDGES;
   localparam int DLY_AW    = (DLY_DEPTH > 1) ? $clog2(DLY_DEPTH) : 1;

   localparam logic [DELAY_W-1:0] QOS_RESET = DELAY_W'(400);

   typedef enum logic [OPCODE_W-1:0] {
      OP_SET_CAP      = 2'd0,
      OP_SET_DELAY    = 2'd1,
      OP_NEW_INTERVAL = 2'd2,
      OP_SERVE        = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_COPY,
      ST_SCAN,
      ST_DECIDE,
      ST_GRANT,
      ST_EMPTY
   } state_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [INDEX_W-1:0]  client_index;
      logic [INDEX_W-1:0]  edge_index;
      logic [AMOUNT_W-1:0] amount;
      logic [DELAY_W-1:0]  delay_value;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  granted_edge;
      logic [AMOUNT_W-1:0] granted_amount;
      logic                grant_valid;
      logic [AMOUNT_W-1:0] unmet_amount;
      logic                last_result;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic clr_step;
      logic load;
      logic table_wr;
      logic sweep_start;
      logic copy;
      logic scan;
      logic grant;
      logic load_empty;
      logic present;
      logic present_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       clr_done;
      opcode_type opcode;
      logic       demand_zero;
      logic       sweep_done;
      logic       best_found;
      logic       fills;
      logic       pend;
      logic       out_busy;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/gba_ifs.sv =====
// Request and response channel interfaces of the allocator.
// Depends on gba_pkg for the field widths.
`default_nettype none

interface gba_req_if import gba_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [INDEX_W-1:0]  client_index;
   logic [INDEX_W-1:0]  edge_index;
   logic [AMOUNT_W-1:0] amount;
   logic [DELAY_W-1:0]  delay_value;

   modport source (output valid, opcode, client_index, edge_index, amount, delay_value,
                   input ready);
   modport sink (input valid, opcode, client_index, edge_index, amount, delay_value,
                 output ready);
endinterface

interface gba_rsp_if import gba_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [INDEX_W-1:0]  granted_edge;
   logic [AMOUNT_W-1:0] granted_amount;
   logic                grant_valid;
   logic [AMOUNT_W-1:0] unmet_amount;
   logic                last_result;

   modport source (output valid, granted_edge, granted_amount, grant_valid, unmet_amount,
                   last_result, input ready);
   modport sink (input valid, granted_edge, granted_amount, grant_valid, unmet_amount,
                 last_result, output ready);
endinterface

`default_nettype wire

// ===== rtl/gba_ctrl.sv =====
// Controller state machine of the allocator: sequences clearing, table writes,
// interval refill, delay-order scans and grants. Depends on gba_pkg.
`default_nettype none

module gba_ctrl import gba_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type sts,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (sts.opcode) inside
               OP_SET_CAP, OP_SET_DELAY: begin
                  cmd.table_wr = 1'b1;
                  state_in     = ST_IDLE;
               end
               OP_NEW_INTERVAL: begin
                  cmd.sweep_start = 1'b1;
                  state_in        = ST_COPY;
               end
               default: begin
                  if (sts.demand_zero) begin
                     state_in = ST_EMPTY;
                  end else begin
                     cmd.sweep_start = 1'b1;
                     state_in        = ST_SCAN;
                  end
               end
            endcase
         end
         ST_COPY: begin
            cmd.copy = 1'b1;
            if (sts.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.sweep_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // a held grant is released once we know whether another follows
            if (sts.best_found) begin
               if (sts.pend) begin
                  cmd.present      = 1'b1;
                  cmd.present_last = 1'b0;
               end
               state_in = ST_GRANT;
            end else if (sts.pend) begin
               cmd.present      = 1'b1;
               cmd.present_last = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               state_in = ST_EMPTY;
            end
         end
         ST_GRANT: begin
            if (!sts.out_busy) begin
               cmd.grant = 1'b1;
               if (sts.fills) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.sweep_start = 1'b1;
                  state_in        = ST_SCAN;
               end
            end
         end
         ST_EMPTY: begin
            if (!sts.out_busy) begin
               cmd.load_empty = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/gba_datapath.sv =====
// Datapath of the allocator: capacity, remaining and delay memories, the edge
// sweep with its minimum search, grant arithmetic and the response register.
// Depends on gba_pkg.
`default_nettype none

module gba_datapath import gba_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cmd_type         cmd,
   output status_type           sts,
   input  wire req_payload_type req_data,
   input  wire logic            csr_wr_en,
   input  wire logic [DELAY_W-1:0] csr_wr_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_data
);

   // configuration
   logic [DELAY_W-1:0] qos_ff;

   // latched request
   opcode_type          op_ff;
   logic [INDEX_W-1:0]  cl_ff;
   logic [INDEX_W-1:0]  ed_ff;
   logic [DELAY_W-1:0]  dv_ff;
   logic [AMOUNT_W-1:0] demand_ff;
   logic [AMOUNT_W-1:0] demand_in;

   // clearing pass
   logic [DLY_AW-1:0] clr_ff;

   // sweep
   logic [EDGE_W-1:0] idx_ff;
   logic              issue_ff;
   logic              pv_ff;
   logic              plast_ff;
   logic [EDGE_W-1:0] pidx_ff;

   // memories and their registered read data
   logic [AMOUNT_W-1:0] cap_mem [EDGES];
   logic [AMOUNT_W-1:0] rem_mem [EDGES];
   logic [DELAY_W-1:0]  dly_mem [DLY_DEPTH];
   logic [AMOUNT_W-1:0] cap_rd_ff;
   logic [AMOUNT_W-1:0] rem_rd_ff;
   logic [DELAY_W-1:0]  dly_rd_ff;

   // best candidate of the current scan
   logic                best_found_ff;
   logic [EDGE_W-1:0]   best_idx_ff;
   logic [DELAY_W-1:0]  best_d_ff;
   logic [AMOUNT_W-1:0] best_rem_ff;

   // response register
   logic            rsp_valid_ff;
   logic            pend_ff;
   rsp_payload_type rsp_ff;

   logic                cl_ok;
   logic                ed_ok;
   logic                clr_low;
   logic                usable;
   logic                rem_short;
   logic [AMOUNT_W-1:0] grant_amt;

   logic                cap_we;
   logic [EDGE_W-1:0]   cap_wa;
   logic [AMOUNT_W-1:0] cap_wd;
   logic                rem_we;
   logic [EDGE_W-1:0]   rem_wa;
   logic [AMOUNT_W-1:0] rem_wd;
   logic                dly_we;
   logic [DLY_AW-1:0]   dly_wa;
   logic [DELAY_W-1:0]  dly_wd;
   logic [DLY_AW-1:0]   dly_ra;

   assign cl_ok   = 32'(cl_ff) < CLIENTS;
   assign ed_ok   = 32'(ed_ff) < EDGES;
   assign clr_low = 32'(clr_ff) < EDGES;

   assign rem_short = best_rem_ff < demand_ff;
   assign grant_amt = rem_short ? best_rem_ff : demand_ff;
   assign demand_in = demand_ff - grant_amt;

   assign dly_ra = DLY_AW'(32'(cl_ff) * EDGES + 32'(idx_ff));

   // write port selection
   always_comb begin
      cap_we = 1'b0;
      cap_wa = ed_ff[EDGE_W-1:0];
      cap_wd = demand_ff;
      if (cmd.clr_step) begin
         cap_we = clr_low;
         cap_wa = clr_ff[EDGE_W-1:0];
         cap_wd = '0;
      end else if (cmd.table_wr && op_ff == OP_SET_CAP) begin
         cap_we = ed_ok;
      end

      rem_we = 1'b0;
      rem_wa = best_idx_ff;
      rem_wd = best_rem_ff - grant_amt;
      if (cmd.clr_step) begin
         rem_we = clr_low;
         rem_wa = clr_ff[EDGE_W-1:0];
         rem_wd = '0;
      end else if (cmd.copy && pv_ff) begin
         rem_we = 1'b1;
         rem_wa = pidx_ff;
         rem_wd = cap_rd_ff;
      end else if (cmd.grant) begin
         rem_we = 1'b1;
      end

      dly_we = 1'b0;
      dly_wa = DLY_AW'(32'(cl_ff) * EDGES + 32'(ed_ff));
      dly_wd = dv_ff;
      if (cmd.clr_step) begin
         dly_we = 1'b1;
         dly_wa = clr_ff;
         dly_wd = '1;
      end else if (cmd.table_wr && op_ff == OP_SET_DELAY) begin
         dly_we = ed_ok && cl_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (cap_we) begin
         cap_mem[cap_wa] <= cap_wd;
      end
      cap_rd_ff <= cap_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (rem_we) begin
         rem_mem[rem_wa] <= rem_wd;
      end
      rem_rd_ff <= rem_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (dly_we) begin
         dly_mem[dly_wa] <= dly_wd;
      end
      dly_rd_ff <= dly_mem[dly_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qos_ff <= QOS_RESET;
      end else if (csr_wr_en) begin
         qos_ff <= csr_wr_data;
      end
   end

   // latched request; demand shrinks with each grant
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= opcode_type'(req_data.opcode);
         cl_ff     <= req_data.client_index;
         ed_ff     <= req_data.edge_index;
         dv_ff     <= req_data.delay_value;
         demand_ff <= req_data.amount;
      end else if (cmd.grant) begin
         demand_ff <= demand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + DLY_AW'(1);
      end
   end

   // sweep: issue one edge address a cycle, evaluate it in the cycle after
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         pv_ff    <= 1'b0;
         plast_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         pv_ff    <= issue_ff;
         plast_ff <= issue_ff && idx_ff == EDGE_W'(EDGES - 1);
         if (cmd.sweep_start) begin
            issue_ff <= 1'b1;
            idx_ff   <= '0;
         end else if (issue_ff) begin
            if (idx_ff == EDGE_W'(EDGES - 1)) begin
               issue_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + EDGE_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= idx_ff;
   end

   // strict less-than keeps the lower index on equal delays
   assign usable = cl_ok && dly_rd_ff < qos_ff && rem_rd_ff != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         best_found_ff <= 1'b0;
      end else if (cmd.sweep_start) begin
         best_found_ff <= 1'b0;
      end else if (cmd.scan && pv_ff && usable) begin
         if (!best_found_ff || dly_rd_ff < best_d_ff) begin
            best_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan && pv_ff && usable && (!best_found_ff || dly_rd_ff < best_d_ff)) begin
         best_idx_ff <= pidx_ff;
         best_d_ff   <= dly_rd_ff;
         best_rem_ff <= rem_rd_ff;
      end
   end

   // response register: a grant is held until the next scan settles its last mark
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.grant) begin
            rsp_valid_ff <= !rem_short;
            pend_ff      <= rem_short;
         end
         if (cmd.load_empty) begin
            rsp_valid_ff <= 1'b1;
         end
         if (cmd.present) begin
            rsp_valid_ff <= 1'b1;
            pend_ff      <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.grant) begin
         rsp_ff.granted_edge   <= INDEX_W'(best_idx_ff);
         rsp_ff.granted_amount <= grant_amt;
         rsp_ff.grant_valid    <= 1'b1;
         rsp_ff.unmet_amount   <= demand_in;
         rsp_ff.last_result    <= !rem_short;
      end else if (cmd.load_empty) begin
         rsp_ff.granted_edge   <= '0;
         rsp_ff.granted_amount <= '0;
         rsp_ff.grant_valid    <= 1'b0;
         rsp_ff.unmet_amount   <= demand_ff;
         rsp_ff.last_result    <= 1'b1;
      end else if (cmd.present) begin
         rsp_ff.last_result <= cmd.present_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign sts.clr_done    = clr_ff == DLY_AW'(DLY_DEPTH - 1);
   assign sts.opcode      = op_ff;
   assign sts.demand_zero = demand_ff == '0;
   assign sts.sweep_done  = pv_ff && plast_ff;
   assign sts.best_found  = best_found_ff;
   assign sts.fills       = !rem_short;
   assign sts.pend        = pend_ff;
   assign sts.out_busy    = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/greedy_bandwidth_allocator_top.sv =====
// Capacity and delay loads write one table entry; a new interval makes one pass of the
// remaining-capacity memory, copying each capacity into it. A nonzero demand runs one
// delay-order scan per grant, plus a closing scan when no grant fills the demand; a zero
// demand runs none. One request at a time; the scan reads one edge a cycle from the delay
// and remaining memories. After reset a clearing pass fills the delay table before
// the first request is taken.
`default_nettype none

module greedy_bandwidth_allocator_top import gba_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   gba_req_if.sink                 req_bus,
   gba_rsp_if.source               rsp_bus,
   input  wire logic               csr_wr_en,
   input  wire logic [DELAY_W-1:0] csr_wr_data
);

   cmd_type         cmd;
   status_type      sts;
   req_payload_type req_data;
   rsp_payload_type rsp_data;
   logic            req_ready;
   logic            rsp_valid;

   assign req_data.opcode       = req_bus.opcode;
   assign req_data.client_index = req_bus.client_index;
   assign req_data.edge_index   = req_bus.edge_index;
   assign req_data.amount       = req_bus.amount;
   assign req_data.delay_value  = req_bus.delay_value;
   assign req_bus.ready         = req_ready;

   gba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gba_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_data    (rsp_data)
   );

   assign rsp_bus.valid          = rsp_valid;
   assign rsp_bus.granted_edge   = rsp_data.granted_edge;
   assign rsp_bus.granted_amount = rsp_data.granted_amount;
   assign rsp_bus.grant_valid    = rsp_data.grant_valid;
   assign rsp_bus.unmet_amount   = rsp_data.unmet_amount;
   assign rsp_bus.last_result    = rsp_data.last_result;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for greedy_bandwidth_allocator_top: predicts every grant of the
// lowest-delay allocator and compares it with the response channel. Depends on gba_pkg, the
// channel interfaces in gba_ifs.sv and the allocator RTL.
`default_nettype none

module tb;
   import gba_pkg::*;

   localparam int ITEMS_PER_PHASE = 24;
   localparam int PHASES          = 5;
   localparam int SETTLE_CYCLES   = 2 * EDGES + 16;
   localparam int RUN_LIMIT       = 40_000_000;
   localparam int REPORT_CAP      = 40;
   localparam int CLIENT_POOL     = 3;
   localparam int EDGE_POOL       = 10;

   // Predicts the allocator's grants and holds them until the response channel delivers.
   class allocation_board;
      rsp_payload_type     expected_allocs[$];
      logic [AMOUNT_W-1:0] capacity[EDGES];
      logic [AMOUNT_W-1:0] remaining[EDGES];
      logic [DELAY_W-1:0]  delay_map[CLIENTS][EDGES];
      logic [DELAY_W-1:0]  qos_limit;
      int                  mismatches;
      int                  demands;
      int                  grants;
      int                  empty_results;

      function new();
         for (int e = 0; e < EDGES; e++) begin
            capacity[e]  = '0;
            remaining[e] = '0;
            for (int c = 0; c < CLIENTS; c++) delay_map[c][e] = '1;
         end
         qos_limit     = QOS_RESET;
         mismatches    = 0;
         demands       = 0;
         grants        = 0;
         empty_results = 0;
      endfunction

      task report_mismatch(input string what);
         if (mismatches < REPORT_CAP) $display("MISMATCH at %0t: %s", $time, what);
         mismatches++;
      endtask

      function void queue_result(input rsp_payload_type r);
         expected_allocs.insert(expected_allocs.size(), r);
      endfunction

      function void note_request(input req_payload_type p);
         bit                  used[EDGES];
         logic [AMOUNT_W-1:0] demand;
         logic [AMOUNT_W-1:0] take;
         logic [DELAY_W-1:0]  d;
         rsp_payload_type     prev;
         bit                  have_prev;
         int                  best;
         int                  e;
         case (opcode_type'(p.opcode))
            OP_SET_CAP:      capacity[p.edge_index] = p.amount;
            OP_SET_DELAY:    delay_map[p.client_index][p.edge_index] = p.delay_value;
            OP_NEW_INTERVAL: for (e = 0; e < EDGES; e++) remaining[e] = capacity[e];
            OP_SERVE: begin
               demands++;
               used      = '{default: 1'b0};
               demand    = p.amount;
               have_prev = 1'b0;
               prev      = '0;
               best      = 0;
               while (demand != 0 && best >= 0) begin
                  best = -1;
                  for (e = 0; e < EDGES; e++) begin
                     d = delay_map[p.client_index][e];
                     if (!used[e] && d < qos_limit && remaining[e] != 0 &&
                         (best < 0 || d < delay_map[p.client_index][best]))
                        best = e;
                  end
                  if (best >= 0) begin
                     used[best] = 1'b1;
                     take = (remaining[best] < demand) ? remaining[best] : demand;
                     remaining[best] -= take;
                     demand -= take;
                     if (have_prev) queue_result(prev);
                     prev = '{granted_edge: INDEX_W'(best), granted_amount: take,
                              grant_valid: 1'b1, unmet_amount: demand, last_result: 1'b0};
                     have_prev = 1'b1;
                  end
               end
               // the final grant carries the last mark; no grant at all gives one empty result
               if (have_prev) begin
                  prev.last_result = 1'b1;
                  queue_result(prev);
               end else begin
                  prev = '{granted_edge: '0, granted_amount: '0,
                           grant_valid: 1'b0, unmet_amount: p.amount,
                           last_result: 1'b1};
                  queue_result(prev);
               end
            end
            default: ;
         endcase
      endfunction

      task check_field(input string name, input logic [31:0] want, input logic [31:0] got);
         if (got !== want)
            report_mismatch($sformatf("%s expected %0d got %0d (demand %0d)",
                                      name, want, got, demands));
      endtask

      task check_result(input rsp_payload_type got);
         rsp_payload_type want;
         if (expected_allocs.size() == 0) begin
            report_mismatch($sformatf("unexpected result edge %0d amount %0d",
                                      got.granted_edge, got.granted_amount));
         end else begin
            want = expected_allocs.pop_front();
            check_field("granted_edge", 32'(want.granted_edge), 32'(got.granted_edge));
            check_field("granted_amount", 32'(want.granted_amount), 32'(got.granted_amount));
            check_field("grant_valid", 32'(want.grant_valid), 32'(got.grant_valid));
            check_field("unmet_amount", 32'(want.unmet_amount), 32'(got.unmet_amount));
            check_field("last_result", 32'(want.last_result), 32'(got.last_result));
            if (want.grant_valid) grants++;
            else empty_results++;
         end
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   logic [DELAY_W-1:0]  csr_wr_data;

   gba_req_if req_bus ();
   gba_rsp_if rsp_bus ();

   greedy_bandwidth_allocator_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   allocation_board    board;
   int                 requests_sent;
   int                 qos_settings;
   bit                 no_gaps;
   logic [INDEX_W-1:0] client_pool[CLIENT_POOL];
   logic [INDEX_W-1:0] edge_pool[EDGE_POOL];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mostly short pauses, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [AMOUNT_W-1:0] pick_amount();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return AMOUNT_W'($urandom_range(0, 15));
      if (r < 55) return AMOUNT_W'($urandom_range(0, 2000));
      if (r < 85) return AMOUNT_W'($urandom);
      case ($urandom_range(0, 2))
         0:       return '0;
         1:       return '1;
         default: return AMOUNT_W'(1);
      endcase
   endfunction

   function automatic req_payload_type make_req(input opcode_type op, input int client,
                                                input int edge_id, input int amount,
                                                input int delay_val);
      req_payload_type p;
      p.opcode       = op;
      p.client_index = INDEX_W'(client);
      p.edge_index   = INDEX_W'(edge_id);
      p.amount       = AMOUNT_W'(amount);
      p.delay_value  = DELAY_W'(delay_val);
      return p;
   endfunction

   // Well-formed traffic on a few clients and edges; unused fields carry noise.
   function automatic req_payload_type random_request();
      req_payload_type p;
      int              pick;
      pick = $urandom_range(0, 99);
      if (pick < 20) p.opcode = OP_SET_CAP;
      else if (pick < 45) p.opcode = OP_SET_DELAY;
      else if (pick < 55) p.opcode = OP_NEW_INTERVAL;
      else p.opcode = OP_SERVE;
      p.client_index = ($urandom_range(0, 99) < 85) ?
                       client_pool[$urandom_range(0, CLIENT_POOL - 1)] : INDEX_W'($urandom);
      p.edge_index   = ($urandom_range(0, 99) < 85) ?
                       edge_pool[$urandom_range(0, EDGE_POOL - 1)] : INDEX_W'($urandom);
      p.amount       = pick_amount();
      // small delays make ties likely
      p.delay_value  = ($urandom_range(0, 1) == 0) ? DELAY_W'($urandom_range(0, 15)) :
                       DELAY_W'($urandom);
      return p;
   endfunction

   function automatic logic [DELAY_W-1:0] qos_for_phase(input int phase);
      case (phase)
         1:       return '0;
         2:       return '1;
         3:       return DELAY_W'(1);
         default: return DELAY_W'($urandom_range(2, 1022));
      endcase
   endfunction

   task automatic send_request(input req_payload_type p);
      int gap;
      gap = no_gaps ? 0 : idle_length();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= p.opcode;
      req_bus.client_index <= p.client_index;
      req_bus.edge_index   <= p.edge_index;
      req_bus.amount       <= p.amount;
      req_bus.delay_value  <= p.delay_value;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(p);
      requests_sent++;
   endtask

   // Hold off until the block is idle: no result pending and any copy pass finished.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (board.expected_allocs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_qos(input logic [DELAY_W-1:0] limit);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.qos_limit = limit;
      qos_settings++;
   endtask

   task automatic run_directed();
      // nothing loaded yet: every delay is all ones
      send_request(make_req(OP_SERVE, 0, 0, 5, 0));
      send_request(make_req(OP_SET_CAP, 0, 0, 20'hFFFFF, 0));
      send_request(make_req(OP_SET_CAP, 0, 63, 1000, 0));
      send_request(make_req(OP_SET_CAP, 0, 5, 300, 0));
      send_request(make_req(OP_SET_DELAY, 63, 63, 20'hFFFFF, 0));
      send_request(make_req(OP_SET_DELAY, 63, 0, 0, 1022));
      send_request(make_req(OP_SET_DELAY, 63, 5, 0, 0));
      // capacities are loaded but not yet refilled
      send_request(make_req(OP_SERVE, 63, 0, 10, 0));
      send_request(make_req(OP_NEW_INTERVAL, 0, 0, 0, 0));
      send_request(make_req(OP_SERVE, 63, 0, 0, 0));
      // tie on delay 0 goes to edge 5 first
      send_request(make_req(OP_SERVE, 63, 0, 700, 0));
      send_request(make_req(OP_SERVE, 63, 63, 20'hFFFFF, 1023));
      send_request(make_req(OP_SERVE, 63, 0, 50, 0));
      send_request(make_req(OP_SET_DELAY, 0, 1, 0, 1023));
      send_request(make_req(OP_SET_CAP, 0, 1, 77, 0));
      send_request(make_req(OP_NEW_INTERVAL, 63, 63, 20'hFFFFF, 1023));
      // delay at the top of the range is never usable
      send_request(make_req(OP_SERVE, 0, 0, 100, 0));
      send_request(make_req(OP_SET_DELAY, 63, 5, 0, 512));
      send_request(make_req(OP_SERVE, 63, 0, 20'hFFFFF, 0));
      send_request(make_req(OP_SET_CAP, 0, 0, 0, 0));
      send_request(make_req(OP_NEW_INTERVAL, 0, 0, 0, 0));
      send_request(make_req(OP_SERVE, 63, 0, 1500, 0));
   endtask

   initial begin : rsp_stall_gen
      int n;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         n = idle_length();
         if (n > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 200)) @(posedge clock);
         else repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_payload_type seen;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.granted_edge   = rsp_bus.granted_edge;
         seen.granted_amount = rsp_bus.granted_amount;
         seen.grant_valid    = rsp_bus.grant_valid;
         seen.unmet_amount   = rsp_bus.unmet_amount;
         seen.last_result    = rsp_bus.last_result;
         board.check_result(seen);
      end
   end

   initial begin : stimulus
      int phase;
      board         = new();
      requests_sent = 0;
      qos_settings  = 0;
      no_gaps       = 1'b0;
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_wr_data          <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.opcode       <= '0;
      req_bus.client_index <= '0;
      req_bus.edge_index   <= '0;
      req_bus.amount       <= '0;
      req_bus.delay_value  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      apply_qos('1);
      run_directed();
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         apply_qos(qos_for_phase(phase));
         foreach (client_pool[i]) client_pool[i] = INDEX_W'($urandom);
         foreach (edge_pool[i]) edge_pool[i] = INDEX_W'($urandom);
         no_gaps = ($urandom_range(0, 3) == 0);
         repeat (ITEMS_PER_PHASE) send_request(random_request());
      end
      settle();
      $display("Covered %0d requests: %0d demands, %0d grants, %0d empty results,",
               requests_sent, board.demands, board.grants, board.empty_results);
      $display("over %0d qos_limit settings with %0d mismatches",
               qos_settings, board.mismatches);
      if (board.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT);
      $display("Timeout with %0d results outstanding", board.expected_allocs.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
